/* rtl/core/svrp_pkg.sv */
`default_nettype none

package svrp_pkg;

    // Field and register widths.
    localparam int VEL_BITS = 24;
    localparam int ACC_W    = 20;
    localparam int CLK_W    = 24;
    localparam int PRE_W    = 16;
    localparam int TGT_W    = 24;
    localparam int IDX_W    = 2;
    localparam int CFG_W    = 24;

    // Working width for ramp arithmetic: covers velocity, target and step with headroom.
    localparam int RW0      = (VEL_BITS > ACC_W) ? VEL_BITS : ACC_W;
    localparam int RW1      = (RW0 > TGT_W) ? RW0 : TGT_W;
    localparam int RW       = RW1 + 2;

    // Speed is the velocity magnitude, which fits VEL_BITS unsigned bits.
    localparam int SPD_W    = VEL_BITS;
    localparam int PROD_W   = SPD_W + 1 + PRE_W;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_ACCEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_CLOCK = 2'd1;
    localparam logic [IDX_W-1:0] REG_FLOOR = 2'd2;
    localparam logic [IDX_W-1:0] REG_CEIL  = 2'd3;

    // Reset values.
    localparam logic [ACC_W-1:0] ACCEL_RST = ACC_W'(1000);
    localparam logic [CLK_W-1:0] CLOCK_RST = CLK_W'(1000000);
    localparam logic [PRE_W-1:0] FLOOR_RST = PRE_W'(1);
    localparam logic [PRE_W-1:0] CEIL_RST  = PRE_W'(65535);

    // Saturate a wide signed value into the signed velocity range.
    function automatic logic signed [VEL_BITS-1:0] vel_sat(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        logic signed [VEL_BITS-1:0] res;
        hi = signed'(RW'({1'b0, {(VEL_BITS-1){1'b1}}}));
        lo = -hi - RW'(1);
        if (x > hi) begin
            res = hi[VEL_BITS-1:0];
        end else if (x < lo) begin
            res = lo[VEL_BITS-1:0];
        end else begin
            res = x[VEL_BITS-1:0];
        end
        return res;
    endfunction

    // One ramp step of v toward t, limited to a.
    function automatic logic signed [VEL_BITS-1:0] ramp_step(
        input logic signed [VEL_BITS-1:0] v,
        input logic signed [VEL_BITS-1:0] t,
        input logic [ACC_W-1:0]           a
    );
        logic signed [RW-1:0] vx;
        logic signed [RW-1:0] tx;
        logic signed [RW-1:0] ax;
        logic signed [RW-1:0] err;
        logic signed [VEL_BITS-1:0] res;
        vx  = RW'(v);
        tx  = RW'(t);
        ax  = signed'(RW'(a));
        err = tx - vx;
        if (err > ax) begin
            res = vel_sat(vx + ax);
        end else if (err < -ax) begin
            res = vel_sat(vx - ax);
        end else begin
            res = t;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/stepper_velocity_ramp_prescaler_unit.sv */
`default_nettype none

// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_run_enable, i_target_velocity
// output    o_out_valid / i_out_ready  o_drive_enable, o_step_direction,
//                                      o_timer_prescale, o_present_velocity
// config    i_cfg_we (no wait)         i_cfg_addr, i_cfg_wdata
//
// An enabled item goes through two ramp steps, two passes through the shared multiplier for the
// range checks, and the divide state, where the bit-serial divider forms the prescaler. When a
// limit sets the prescaler the divider is skipped. A disabled item skips all of these and goes
// straight to the final state.
// Reset is synchronous and restores the register defaults and the held state.
// A finished result waits in the output register; the next item is taken meanwhile,
// and its result waits in the final state until the output register is free.
module stepper_velocity_ramp_prescaler_unit import svrp_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_run_enable,
    input  wire logic signed [TGT_W-1:0]    i_target_velocity,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_drive_enable,
    output logic                            o_step_direction,
    output logic [PRE_W-1:0]                o_timer_prescale,
    output logic signed [TGT_W-1:0]         o_present_velocity,
    input  wire logic                       i_cfg_we,
    input  wire logic [IDX_W-1:0]           i_cfg_addr,
    input  wire logic [CFG_W-1:0]           i_cfg_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RAMP1 = 4'd1;
    localparam logic [3:0] S_SIGN  = 4'd2;
    localparam logic [3:0] S_MUL1  = 4'd3;
    localparam logic [3:0] S_MUL2  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_RAMP2 = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]                 r_state;
    logic [ACC_W-1:0]           r_accel;
    logic [CLK_W-1:0]           r_clock;
    logic [PRE_W-1:0]           r_floor;
    logic [PRE_W-1:0]           r_ceil;
    logic signed [VEL_BITS-1:0] r_vel;
    logic signed [VEL_BITS-1:0] r_tgt;
    logic                       r_dir;
    logic                       r_en;
    logic [PRE_W-1:0]           r_presc;
    logic [SPD_W-1:0]           r_speed;
    logic [PROD_W-1:0]          r_prod;
    logic                       r_low;
    logic                       r_out_valid;
    logic                       r_out_en;
    logic                       r_out_dir;
    logic [PRE_W-1:0]           r_out_presc;
    logic signed [TGT_W-1:0]    r_out_vel;

    logic signed [VEL_BITS-1:0] tgt_sat;
    logic [PRE_W-1:0]           fl_eff;
    logic [PRE_W-1:0]           ce_eff;
    logic [PROD_W-1:0]          clk_ext;
    logic [SPD_W:0]             mul_a;
    logic [PRE_W-1:0]           mul_b;
    logic [SPD_W-1:0]           speed_now;
    logic                       div_start;
    logic                       div_done;
    logic [CLK_W-1:0]           div_quo;
    logic signed [RW-1:0]       vel_wide;
    logic                       out_free;
    logic                       in_acc;

    assign tgt_sat  = vel_sat(RW'(i_target_velocity));
    assign fl_eff   = (r_floor == '0) ? PRE_W'(1) : r_floor;
    assign ce_eff   = (r_ceil == '0) ? PRE_W'(1) : r_ceil;
    assign clk_ext  = PROD_W'(r_clock);
    assign vel_wide = RW'(r_vel);
    assign out_free = !r_out_valid || i_out_ready;
    assign in_acc   = i_in_valid && o_in_ready;

    // Magnitude of the velocity; the most negative value maps to 2^(VEL_BITS-1).
    assign speed_now = r_vel[VEL_BITS-1] ? SPD_W'(-r_vel) : SPD_W'(r_vel);

    // Shared multiplier: (speed + 1) * ceiling first, then speed * floor.
    assign mul_a = (r_state == S_MUL1) ? ({1'b0, r_speed} + (SPD_W+1)'(1))
                                       : {1'b0, r_speed};
    assign mul_b = (r_state == S_MUL1) ? ce_eff : fl_eff;

    assign div_start = (r_state == S_CHK) && (r_speed != '0) && !r_low &&
                       !(r_prod > clk_ext);

    svrp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_clock),
        .i_divisor  (r_speed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_accel     <= ACCEL_RST;
            r_clock     <= CLOCK_RST;
            r_floor     <= FLOOR_RST;
            r_ceil      <= CEIL_RST;
            r_vel       <= '0;
            r_dir       <= 1'b0;
            r_en        <= 1'b0;
            r_presc     <= CEIL_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_ACCEL: r_accel <= i_cfg_wdata[ACC_W-1:0];
                    REG_CLOCK: r_clock <= i_cfg_wdata[CLK_W-1:0];
                    REG_FLOOR: r_floor <= i_cfg_wdata[PRE_W-1:0];
                    REG_CEIL:  r_ceil  <= i_cfg_wdata[PRE_W-1:0];
                endcase
            end

            // In the final state the output register is reloaded below instead.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tgt <= tgt_sat;
                        r_en  <= i_run_enable;
                        if (i_run_enable) begin
                            // Enabling a stopped drive starts the ramp from rest.
                            if (!r_en) begin
                                r_vel <= '0;
                            end
                            r_state <= S_RAMP1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RAMP1: begin
                    r_vel   <= ramp_step(r_vel, r_tgt, r_accel);
                    r_state <= S_SIGN;
                end
                S_SIGN: begin
                    r_speed <= speed_now;
                    if (r_vel != '0) begin
                        r_dir <= !r_vel[VEL_BITS-1];
                    end
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod  <= PROD_W'(mul_a * mul_b);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    // speed < clock / ceiling holds exactly when (speed + 1) * ceiling <= clock.
                    r_low   <= (r_prod <= clk_ext);
                    r_prod  <= PROD_W'(mul_a * mul_b);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if ((r_speed == '0) || r_low) begin
                        r_presc <= ce_eff;
                        r_state <= S_RAMP2;
                    end else if (r_prod > clk_ext) begin
                        // speed > clock / floor holds exactly when speed * floor > clock.
                        r_presc <= fl_eff;
                        r_state <= S_RAMP2;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_presc <= (div_quo > CLK_W'(ce_eff)) ? ce_eff : div_quo[PRE_W-1:0];
                        r_state <= S_RAMP2;
                    end
                end
                S_RAMP2: begin
                    r_vel   <= ramp_step(r_vel, r_tgt, r_accel);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_en    <= r_en;
                        r_out_dir   <= r_dir;
                        r_out_presc <= r_presc;
                        r_out_vel   <= vel_wide[TGT_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_drive_enable     = r_out_en;
    assign o_step_direction   = r_out_dir;
    assign o_timer_prescale   = r_out_presc;
    assign o_present_velocity = r_out_vel;

    property p_disabled_holds;
        @(posedge i_clk) disable iff (!i_rst_n)
            (in_acc && !i_run_enable) |=>
            (r_vel == $past(r_vel) && r_presc == $past(r_presc) && r_dir == $past(r_dir));
    endproperty
    a_disabled_holds: assert property (p_disabled_holds)
        else $error("disabled item changed the held state");

    property p_presc_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) r_presc != '0;
    endproperty
    a_presc_nonzero: assert property (p_presc_nonzero)
        else $error("held prescaler is zero");

    property p_done_delivers;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE);
    endproperty
    a_done_delivers: assert property (p_done_delivers)
        else $error("finished item not moved to the output register");

    property p_div_in_div_state;
        @(posedge i_clk) disable iff (!i_rst_n) div_done |-> (r_state == S_DIV);
    endproperty
    a_div_in_div_state: assert property (p_div_in_div_state)
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

/* rtl/core/svrp_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module svrp_div import svrp_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CLK_W-1:0] i_dividend,
    input  wire logic [SPD_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [CLK_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(CLK_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SPD_W-1:0] r_rem;
    logic [CLK_W-1:0] r_quo;

    logic [SPD_W:0]   shifted;
    logic [SPD_W+1:0] diff;

    assign shifted = {r_rem, r_quo[CLK_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CLK_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so it fits SPD_W bits.
                if (!diff[SPD_W+1]) begin
                    r_rem <= diff[SPD_W-1:0];
                    r_quo <= {r_quo[CLK_W-2:0], 1'b1};
                end else begin
                    r_rem <= shifted[SPD_W-1:0];
                    r_quo <= {r_quo[CLK_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    property p_no_start_while_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_start;
    endproperty
    a_no_start_while_busy: assert property (p_no_start_while_busy)
        else $error("divider restarted while busy");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> (!r_busy && $past(r_busy));
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a running division");

    property p_count_bounded;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_cnt != '0);
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("divider count ran out while busy");

endmodule

`default_nettype wire
